/* design/b64e_pkg.sv */
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the alphabet lookup of the streaming base64
// encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

	// Register map: one register every four bytes.
	localparam int unsigned REG_ADDR_W = 3;
	localparam logic REG_NEWLINE_ENABLE = 1'b0;
	localparam logic REG_LINE_LIMIT = 1'b1;

	localparam logic [7:0] LINE_LIMIT_RESET = 8'd72;

	// Characters that are not taken from the alphabet.
	localparam logic [6:0] CHAR_LF = 7'h0A;
	localparam logic [6:0] CHAR_PAD = 7'h3D;

	// Most characters that one input item can cause.
	localparam int unsigned MAX_CHARS = 5;
	localparam int unsigned CNT_W = $clog2(MAX_CHARS + 1);
	localparam int unsigned IDX_W = $clog2(MAX_CHARS);

	// Default number of jobs held between the front and the back.
	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	// One classified input item: the characters to send, in order.
	typedef struct packed {
		logic [MAX_CHARS-1:0][6:0] chars;
		logic [CNT_W-1:0] count;
		logic last;
	} job_t;

	// Fill status of the job queue.
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	// Maps a six-bit value onto the standard base64 alphabet.
	function automatic logic [6:0] b64_char(input logic [5:0] v);
		logic [6:0] v7;
		logic [6:0] ch;
		v7 = {1'b0, v};
		if (v < 6'd26) begin
			ch = v7 + 7'h41;
		end else if (v < 6'd52) begin
			ch = v7 + 7'h47;
		end else if (v < 6'd62) begin
			ch = v7 - 7'd4;
		end else if (v == 6'd62) begin
			ch = 7'h2B;
		end else begin
			ch = 7'h2F;
		end
		return ch;
	endfunction

endpackage

/* design/b64e_front.sv */
// ----------------------------------------------------------------------------
// b64e_front
// Accepts input items, keeps the group and line state and turns each item
// into a job of up to five characters for the back end.
// ----------------------------------------------------------------------------
module b64e_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           data_byte,
	input  logic                 end_only,
	input  logic                 msg_last,
	input  logic                 newline_enable,
	input  logic [7:0]           line_limit,
	input  b64e_pkg::queue_status_t qst,
	output logic                 push,
	output b64e_pkg::job_t       job
);
	import b64e_pkg::*;

	logic [15:0] held_q;
	logic [1:0]  phase_q;
	logic [7:0]  line_cnt_q;

	logic        accept;
	logic        full_grp;
	logic [1:0]  phase_mid;
	logic [15:0] held_mid;
	logic        grp_emit;
	logic [7:0]  b0;
	logic [7:0]  b1;
	logic [7:0]  b2;
	logic [8:0]  cnt_sum;
	logic [7:0]  cnt_grp;
	logic        lf_limit;
	logic [7:0]  cnt_after;
	logic        lf_end;
	logic [6:0]  g0;
	logic [6:0]  g1;
	logic [6:0]  g2;
	logic [6:0]  g3;

	// Items wait only while the job queue is full.
	assign in_stall = qst.full;
	assign accept = in_valid && !qst.full;

	// A data byte on top of two held bytes completes a group.
	assign full_grp = !end_only && phase_q[1];

	// Byte holding for items that do not complete a group.
	always_comb begin
		phase_mid = phase_q;
		held_mid = held_q;
		if (full_grp) begin
			phase_mid = 2'd0;
			held_mid = '0;
		end else if (!end_only) begin
			if (phase_q == 2'd0) begin
				phase_mid = 2'd1;
				held_mid = {data_byte, 8'h00};
			end else begin
				phase_mid = 2'd2;
				held_mid = {held_q[15:8], data_byte};
			end
		end
	end

	// Group characters; a partial group at message end is padded.
	assign grp_emit = full_grp || (msg_last && (phase_mid != 2'd0));
	assign b0 = full_grp ? held_q[15:8] : held_mid[15:8];
	assign b1 = full_grp ? held_q[7:0] : held_mid[7:0];
	assign b2 = full_grp ? data_byte : 8'h00;
	assign g0 = b64_char(b0[7:2]);
	assign g1 = b64_char({b0[1:0], b1[7:4]});
	assign g2 = (full_grp || phase_mid[1]) ? b64_char({b1[3:0], b2[7:6]}) : CHAR_PAD;
	assign g3 = full_grp ? b64_char(b2[5:0]) : CHAR_PAD;

	// Line counting with saturation, and the two kinds of line feed.
	assign cnt_sum = {1'b0, line_cnt_q} + 9'd4;
	assign cnt_grp = !grp_emit ? line_cnt_q : (cnt_sum[8] ? 8'hFF : cnt_sum[7:0]);
	assign lf_limit = full_grp && newline_enable && (cnt_grp >= line_limit);
	assign cnt_after = lf_limit ? 8'd0 : cnt_grp;
	assign lf_end = msg_last && newline_enable && (cnt_after != 8'd0);

	// Job assembly: a line feed is in slot four after a group, else slot zero.
	always_comb begin
		job.chars[0] = grp_emit ? g0 : CHAR_LF;
		job.chars[1] = g1;
		job.chars[2] = g2;
		job.chars[3] = g3;
		job.chars[4] = CHAR_LF;
		job.count = (grp_emit ? CNT_W'(4) : CNT_W'(0)) + CNT_W'(lf_limit || lf_end);
		job.last = msg_last;
	end

	assign push = accept && (job.count != '0);

	// Group and line state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			phase_q <= 2'd0;
			line_cnt_q <= 8'd0;
		end else if (accept) begin
			if (msg_last) begin
				held_q <= '0;
				phase_q <= 2'd0;
				line_cnt_q <= 8'd0;
			end else begin
				held_q <= held_mid;
				phase_q <= phase_mid;
				line_cnt_q <= cnt_after;
			end
		end
	end

endmodule

/* design/b64e_queue.sv */
// ----------------------------------------------------------------------------
// b64e_queue
// Short first-in first-out queue of jobs between the front and the back.
// ----------------------------------------------------------------------------
module b64e_queue #(
	parameter int unsigned DEPTH = b64e_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  b64e_pkg::job_t          push_job,
	input  logic                    pop,
	output b64e_pkg::job_t          head,
	output b64e_pkg::queue_status_t qst
);
	import b64e_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned LVL_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [LVL_W-1:0] level_q;

	assign qst.full = (level_q == LVL_W'(DEPTH));
	assign qst.empty = (level_q == '0);
	assign head = mem_q[rd_ptr_q];

	// Job storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

/* design/b64e_back.sv */
// ----------------------------------------------------------------------------
// b64e_back
// Sends the characters of the head job one per cycle, while the output is
// not stalled, through an output register.
// ----------------------------------------------------------------------------
module b64e_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  b64e_pkg::job_t          head,
	input  b64e_pkg::queue_status_t qst,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [6:0]              out_char,
	output logic                    out_last
);
	import b64e_pkg::*;

	logic [IDX_W-1:0] idx_q;
	logic             valid_q;
	logic [6:0]       char_q;
	logic             last_q;
	logic             load;
	logic             final_char;

	// A new character enters when the output register is free or drains.
	assign load = !qst.empty && (!valid_q || !out_stall);
	assign final_char = (CNT_W'(idx_q) == head.count - 1'b1);
	assign pop = load && final_char;

	assign out_valid = valid_q;
	assign out_char = char_q;
	assign out_last = last_q;

	// Character index within the head job and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q <= final_char ? '0 : idx_q + 1'b1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= head.chars[idx_q];
			last_q <= final_char && head.last;
		end
	end

endmodule

/* design/base64_stream_encoder_core.sv */
// ----------------------------------------------------------------------------
// base64_stream_encoder_core
// Streaming base64 encoder with padding, optional line breaking and an end
// of message mark on the last character.
//
//   Channel  Signals                                 Direction
//   input    in_valid, in_stall, data_byte,          in (in_stall out)
//            end_only, msg_last
//   output   out_valid, out_stall, out_char,         out (out_stall in)
//            out_last
//   config   psel, penable, pwrite, paddr, pwdata,   in (prdata, pready out)
//            prdata, pready
//
// An item becomes a job of zero to five characters.
// The output sends one character per cycle while out_stall is low, and a
// completed group makes four or five; the job queue absorbs the difference,
// and inputs stall only while it is full.
// Reset clears the held bytes, the line count, the queue and the output.
// A stalled output holds its character while the front keeps taking items.
// ----------------------------------------------------------------------------
module base64_stream_encoder_core #(
	parameter int unsigned QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [b64e_pkg::REG_ADDR_W-1:0] paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      data_byte,
	input  logic                            end_only,
	input  logic                            msg_last,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [6:0]                      out_char,
	output logic                            out_last
);
	import b64e_pkg::*;

	logic          newline_enable_q;
	logic [7:0]    line_limit_q;
	logic          cfg_wr;
	logic          reg_sel;
	logic          push;
	logic          pop;
	job_t          push_job;
	job_t          head;
	queue_status_t qst;

	// Register port: writes complete in the access cycle.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign reg_sel = paddr[REG_ADDR_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newline_enable_q <= 1'b0;
			line_limit_q <= LINE_LIMIT_RESET;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_NEWLINE_ENABLE: newline_enable_q <= pwdata[0];
				REG_LINE_LIMIT:     line_limit_q <= pwdata[7:0];
				default:            line_limit_q <= line_limit_q;
			endcase
		end
	end

	// Register read back.
	always_comb begin
		unique case (reg_sel)
			REG_NEWLINE_ENABLE: prdata = {31'd0, newline_enable_q};
			REG_LINE_LIMIT:     prdata = {24'd0, line_limit_q};
			default:            prdata = '0;
		endcase
	end

	b64e_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.end_only       (end_only),
		.msg_last       (msg_last),
		.newline_enable (newline_enable_q),
		.line_limit     (line_limit_q),
		.qst            (qst),
		.push           (push),
		.job            (push_job)
	);

	b64e_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.qst      (qst)
	);

	b64e_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qst       (qst),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_char  (out_char),
		.out_last  (out_last)
	);

	// The queue is never both full and empty.
	a_queue_status: assert property (@(posedge clk) disable iff (!arst_n)
		!(qst.full && qst.empty))
		else $error("job queue reports full and empty at once");

	// The back end only retires a job that is present.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qst.empty)
		else $error("job retired from an empty queue");

	// The front end never writes a full queue.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qst.full)
		else $error("job written into a full queue");

	// A job written into an empty queue with a free output is loaded from the
	// queue storage into the output register, and the output then becomes valid.
	a_push_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(push && qst.empty && (!out_valid || !out_stall)) |-> ##2 out_valid)
		else $error("output did not pick up a new job");

endmodule

/* test/base64_stream_encoder_checker.sv */
// ----------------------------------------------------------------------------
// base64_stream_encoder_checker
// Watches the input, output and register ports of the streaming base64
// encoder. It keeps its own copy of the held bytes, group phase, line count
// and settings, encodes every accepted input transfer into the characters the
// block must send, and compares each output transfer with the oldest one.
// ----------------------------------------------------------------------------
module base64_stream_encoder_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [b64e_pkg::REG_ADDR_W-1:0] paddr,
	input  logic [31:0]                     pwdata,
	input  logic                            pready,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic [7:0]                      data_byte,
	input  logic                            end_only,
	input  logic                            msg_last,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic [6:0]                      out_char,
	input  logic                            out_last,
	output int                              fail_count,
	output int                              pending_count,
	output int                              chars_checked
);

	localparam logic [8*64-1:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
	localparam logic [6:0] ASCII_LF = 7'h0A;
	localparam logic [6:0] ASCII_EQ = 7'h3D;
	localparam logic [7:0] LIMIT_AT_RESET = 8'd72;
	localparam int MAX_PER_ITEM = 5;

	typedef struct packed {
		logic [6:0] ch;
		logic last;
	} enc_char_t;

	// Settings as last written over the register port.
	logic lf_on;
	logic [7:0] line_max;

	// Encoder state.
	logic [15:0] held_pair;
	logic [1:0] held_num;
	logic [7:0] col_count;

	// Characters produced by one input transfer, then the queue of those due.
	logic [6:0] step_buf [0:MAX_PER_ITEM-1];
	int step_n;
	enc_char_t due_chars [$];

	enc_char_t head;
	int fails;
	int checked;

	function automatic logic [6:0] sextet_char(input logic [5:0] v);
		int pos;
		pos = 8 * (63 - int'(v));
		return ALPHABET[pos +: 7];
	endfunction

	// The line count sticks at its top value instead of wrapping.
	function automatic logic [7:0] add_four_sat(input logic [7:0] c);
		return (c > 8'd251) ? 8'd255 : c + 8'd4;
	endfunction

	task automatic put_char(input logic [6:0] c);
		if (step_n < MAX_PER_ITEM) begin
			step_buf[step_n] = c;
			step_n++;
		end
	endtask

	// Encodes one input transfer and queues the characters it causes.
	task automatic encode_item(input logic [7:0] b, input logic no_byte, input logic ends);
		logic [7:0] b0;
		logic [7:0] b1;
		enc_char_t e;
		int i;
		step_n = 0;
		b0 = held_pair[15:8];
		b1 = held_pair[7:0];
		if (!no_byte) begin
			case (held_num)
				2'd0: begin
					held_pair = {b, 8'h00};
					held_num = 2'd1;
				end
				2'd1: begin
					held_pair[7:0] = b;
					held_num = 2'd2;
				end
				default: begin
					put_char(sextet_char(b0[7:2]));
					put_char(sextet_char({b0[1:0], b1[7:4]}));
					put_char(sextet_char({b1[3:0], b[7:6]}));
					put_char(sextet_char(b[5:0]));
					held_pair = '0;
					held_num = '0;
					col_count = add_four_sat(col_count);
					if (lf_on && col_count >= line_max) begin
						put_char(ASCII_LF);
						col_count = '0;
					end
				end
			endcase
		end
		// Message end: flush a partial group with padding, then close the line.
		if (ends) begin
			b0 = held_pair[15:8];
			b1 = held_pair[7:0];
			if (held_num == 2'd1) begin
				put_char(sextet_char(b0[7:2]));
				put_char(sextet_char({b0[1:0], 4'h0}));
				put_char(ASCII_EQ);
				put_char(ASCII_EQ);
				col_count = add_four_sat(col_count);
			end else if (held_num != 2'd0) begin
				put_char(sextet_char(b0[7:2]));
				put_char(sextet_char({b0[1:0], b1[7:4]}));
				put_char(sextet_char({b1[3:0], 2'b00}));
				put_char(ASCII_EQ);
				col_count = add_four_sat(col_count);
			end
			if (lf_on && col_count != 8'd0) begin
				put_char(ASCII_LF);
			end
			held_pair = '0;
			held_num = '0;
			col_count = '0;
		end
		for (i = 0; i < step_n; i++) begin
			e.ch = step_buf[i];
			e.last = ends && (i == step_n - 1);
			due_chars.push_back(e);
		end
	endtask

	// Output check first, then prediction, then register writes, so that a
	// setting only affects later transfers.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lf_on = 1'b0;
			line_max = LIMIT_AT_RESET;
			held_pair = '0;
			held_num = '0;
			col_count = '0;
			due_chars.delete();
			fails = 0;
			checked = 0;
			fail_count <= 0;
			pending_count <= 0;
			chars_checked <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (due_chars.size() == 0) begin
					$error("unexpected transfer: out_char actual 0x%02h, out_last actual %0d",
						out_char, out_last);
					fails++;
				end else begin
					head = due_chars.pop_front();
					checked++;
					if (out_char !== head.ch) begin
						$error("out_char mismatch: expected 0x%02h, actual 0x%02h",
							head.ch, out_char);
						fails++;
					end
					if (out_last !== head.last) begin
						$error("out_last mismatch: expected %0d, actual %0d",
							head.last, out_last);
						fails++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				encode_item(data_byte, end_only, msg_last);
			end
			if (psel && penable && pwrite && pready) begin
				if (paddr == {b64e_pkg::REG_NEWLINE_ENABLE, 2'b00}) begin
					lf_on = pwdata[0];
				end else if (paddr == {b64e_pkg::REG_LINE_LIMIT, 2'b00}) begin
					line_max = pwdata[7:0];
				end
			end
			fail_count <= fails;
			pending_count <= due_chars.size();
			chars_checked <= checked;
		end
	end

endmodule

/* test/base64_stream_encoder_core_tb.sv */
// ----------------------------------------------------------------------------
// base64_stream_encoder_core_tb
// Drives the streaming base64 encoder with directed and random messages under
// a range of line feed settings, with random gaps on the input and random
// stalls on the output. A checker beside the block predicts and compares
// every character; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module base64_stream_encoder_core_tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 16;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [b64e_pkg::REG_ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic in_valid;
	logic in_stall;
	logic [7:0] data_byte;
	logic end_only;
	logic msg_last;
	logic out_valid;
	logic out_stall;
	logic [6:0] out_char;
	logic out_last;

	int fail_count;
	int pending_count;
	int chars_checked;

	int cycles = 0;
	int items_sent = 0;
	int phases = 0;
	int in_gap_den;
	int out_gap_den;

	base64_stream_encoder_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.end_only(end_only),
		.msg_last(msg_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_char(out_char),
		.out_last(out_last)
	);

	base64_stream_encoder_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.end_only(end_only),
		.msg_last(msg_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_char(out_char),
		.out_last(out_last),
		.fail_count(fail_count),
		.pending_count(pending_count),
		.chars_checked(chars_checked)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Receiver side: random stall bursts.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (out_gap_den != 0 && $urandom_range(1, out_gap_den) == 1) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// One input transfer, with an optional idle burst ahead of it.
	task automatic send_item(input logic [7:0] b, input logic no_byte, input logic ends);
		if (in_gap_den != 0 && $urandom_range(1, in_gap_den) == 1) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		end_only <= no_byte;
		msg_last <= ends;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
	endtask

	// Register write: setup cycle, then access cycle.
	task automatic write_reg(input logic idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Stop sending and wait until the block has drained.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// A well-formed message of random bytes, ended either on its last byte or
	// by a separate end transfer, with the odd no-op mixed in.
	task automatic send_message(input int len);
		logic by_item;
		int i;
		by_item = ($urandom_range(0, 2) == 0);
		for (i = 0; i < len; i++) begin
			if ($urandom_range(0, 15) == 0) begin
				send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
			end
			send_item(8'($urandom_range(0, 255)), 1'b0, !by_item && (i == len - 1));
		end
		if (by_item) begin
			send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
		end
	endtask

	task automatic random_messages(input int n_items, input int max_len);
		int sent;
		int kind;
		int len;
		sent = 0;
		while (sent < n_items) begin
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
				sent++;
			end else if (kind == 1) begin
				send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
			end else begin
				len = $urandom_range(1, max_len);
				send_message(len);
				sent += len;
			end
		end
	endtask

	// New settings once idle, with random upper bits on the write data.
	task automatic run_phase(input logic nl, input logic [7:0] limit_val, input int n_items,
			input int max_len, input int gap_den);
		logic [31:0] word;
		settle();
		word = $urandom();
		word[0] = nl;
		write_reg(b64e_pkg::REG_NEWLINE_ENABLE, word);
		word = $urandom();
		word[7:0] = limit_val;
		write_reg(b64e_pkg::REG_LINE_LIMIT, word);
		in_gap_den = gap_den;
		out_gap_den = gap_den;
		phases++;
		if (n_items > 0) begin
			random_messages(n_items, max_len);
		end
	endtask

	initial begin
		int i;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		data_byte = '0;
		end_only = 1'b0;
		msg_last = 1'b0;
		in_gap_den = 5;
		out_gap_den = 5;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: line feeds off, limit at its reset value.
		phases++;
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'hFF, 1'b0, 1'b0);
		send_item(8'hFF, 1'b0, 1'b1);
		send_item(8'h00, 1'b0, 1'b0);
		send_item(8'hFF, 1'b0, 1'b0);
		send_item(8'h80, 1'b0, 1'b1);
		// Empty end, then a no-op inside a message ended by its own transfer.
		send_item(8'hA5, 1'b1, 1'b1);
		send_item(8'h5A, 1'b0, 1'b0);
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'hC3, 1'b0, 1'b0);
		send_item(8'h00, 1'b1, 1'b1);
		// A full group followed by an end with nothing held.
		send_item(8'hFB, 1'b0, 1'b0);
		send_item(8'hEF, 1'b0, 1'b0);
		send_item(8'hBE, 1'b0, 1'b0);
		send_item(8'h55, 1'b1, 1'b1);

		// Line feeds on at a limit of four.
		run_phase(1'b1, 8'd4, 0, 0, 5);
		send_item(8'h01, 1'b0, 1'b0);
		send_item(8'h23, 1'b0, 1'b0);
		send_item(8'h45, 1'b0, 1'b1);
		send_item(8'hAA, 1'b0, 1'b1);
		send_item(8'hFF, 1'b1, 1'b1);
		send_item(8'h12, 1'b0, 1'b0);
		send_item(8'h34, 1'b0, 1'b0);
		send_item(8'h56, 1'b0, 1'b0);
		send_item(8'h78, 1'b0, 1'b1);

		// Random messages over a spread of settings.
		run_phase(1'b1, 8'd8, 10, 12, 4);
		run_phase(1'b0, 8'd252, 8, 12, 0);
		run_phase(1'b1, 8'd0, 10, 9, 3);
		run_phase(1'b1, 8'd3, 8, 9, 6);
		run_phase(1'b1, 8'd72, 40, 60, 4);

		// One long line that drives the line count into saturation.
		run_phase(1'b1, 8'd255, 0, 0, 5);
		for (i = 0; i < 195; i++) begin
			send_item(8'($urandom_range(0, 255)), 1'b0, i == 194);
		end

		run_phase(1'b1, 8'($urandom_range(4, 252)), 10, 15, 5);

		// Closing stretch at full rate.
		run_phase(1'b1, 8'd12, 15, 10, 0);

		settle();
		$display("Sent %0d input transfers under %0d register settings; %0d characters checked.",
			items_sent, phases, chars_checked);
		$display("Line feeds off and on, limits 0 to 255, padding, empty ends and no-ops.");
		if (fail_count == 0 && pending_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

/* base64_stream_encoder_core.f */
design/b64e_pkg.sv
design/b64e_front.sv
design/b64e_queue.sv
design/b64e_back.sv
design/base64_stream_encoder_core.sv
test/base64_stream_encoder_checker.sv
test/base64_stream_encoder_core_tb.sv
